// ----- design/hdue_pkg.sv -----
// Shared types, constants and helpers for the half-duplex UART echo unit.
`timescale 1ns / 1ps

package hdue_pkg;

   localparam int DATA_BITS  = 8;
   localparam int TICK_WIDTH = 8;
   localparam int BYTE_WIDTH = 8;
   localparam int CFG_WIDTH  = 8;
   localparam int BIT_COUNT_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CMP_WIDTH = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;

   localparam logic [TICK_WIDTH-1:0]      TICK_MAX        = '1;
   localparam logic [BIT_COUNT_WIDTH-1:0] DATA_BITS_COUNT = BIT_COUNT_WIDTH'(DATA_BITS);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_DELAY = CSR_INDEX_WIDTH'(1);

   localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RESET  = CFG_WIDTH'(2);
   localparam logic [CFG_WIDTH-1:0] START_DELAY_RESET = CFG_WIDTH'(1);

   typedef enum logic [1:0] {
      RX_WAIT  = 2'd0,
      RX_DELAY = 2'd1,
      RX_DATA  = 2'd2,
      RX_STOP  = 2'd3
   } rx_phase_type;

   typedef enum logic [2:0] {
      TX_IDLE   = 3'd0,
      TX_DATA   = 3'd1,
      TX_PARITY = 3'd2,
      TX_STOP   = 3'd3,
      TX_HOLD   = 3'd4
   } tx_phase_type;

   typedef struct packed {
      logic                  tick;
      logic                  rx_line;
      logic                  send_valid;
      logic [BYTE_WIDTH-1:0] send_byte;
   } req_type;

   typedef struct packed {
      logic                  tx_line;
      logic                  busy_res;
      logic                  send_accepted;
      logic                  rx_valid;
      logic [BYTE_WIDTH-1:0] rx_byte;
   } rsp_type;

   typedef struct packed {
      rx_phase_type               phase;
      logic [BYTE_WIDTH-1:0]      shift;
      logic [BIT_COUNT_WIDTH-1:0] bits;
   } rx_state_type;

   typedef struct packed {
      tx_phase_type               phase;
      logic [BYTE_WIDTH-1:0]      shift;
      logic [BIT_COUNT_WIDTH-1:0] bits;
      logic                       parity;
      logic                       level;
      logic                       busy;
   } tx_state_type;

   typedef struct packed {
      logic                  valid;
      logic [BYTE_WIDTH-1:0] data;
   } echo_type;

   function automatic logic tick_reached(input logic [TICK_WIDTH-1:0] count,
                                         input logic [CFG_WIDTH-1:0]  limit);
      return CMP_WIDTH'(count) >= CMP_WIDTH'(limit);
   endfunction

endpackage

// ----- design/hdue_rx.sv -----
// Receiver step: tick advance, start detect, data sampling and stop delivery.
`timescale 1ns / 1ps

module hdue_rx (
   input  logic                             tick,
   input  logic                             rx_line,
   input  logic                             tx_busy,
   input  logic [hdue_pkg::TICK_WIDTH-1:0]  tick_count,
   input  logic [hdue_pkg::CFG_WIDTH-1:0]   bit_period,
   input  logic [hdue_pkg::CFG_WIDTH-1:0]   start_delay,
   input  hdue_pkg::rx_state_type           rx_cur,
   output hdue_pkg::rx_state_type           rx_nxt,
   output logic [hdue_pkg::TICK_WIDTH-1:0]  tick_nxt,
   output hdue_pkg::echo_type               echo
);
   import hdue_pkg::*;

   logic [TICK_WIDTH-1:0] tick_adv;

   always_comb begin
      tick_adv = tick_count;
      if (tick && (tick_count != TICK_MAX)) begin
         tick_adv = tick_count + TICK_WIDTH'(1);
      end
   end

   always_comb begin
      rx_nxt     = rx_cur;
      tick_nxt   = tick_adv;
      echo.valid = 1'b0;
      echo.data  = '0;
      if (!tx_busy) begin
         case (rx_cur.phase)
            RX_WAIT: begin
               if (!rx_line) begin
                  tick_nxt     = '0;
                  rx_nxt.phase = RX_DELAY;
               end
            end
            RX_DELAY: begin
               if (tick_reached(tick_adv, start_delay)) begin
                  tick_nxt     = '0;
                  rx_nxt.phase = RX_DATA;
               end
            end
            RX_DATA: begin
               if (tick_reached(tick_adv, bit_period)) begin
                  if (rx_cur.bits < DATA_BITS_COUNT) begin
                     rx_nxt.shift = {rx_line, rx_cur.shift[BYTE_WIDTH-1:1]};
                     rx_nxt.bits  = rx_cur.bits + BIT_COUNT_WIDTH'(1);
                  end else begin
                     rx_nxt.phase = RX_STOP;
                  end
                  tick_nxt = '0;
               end
            end
            RX_STOP: begin
               if (tick_reached(tick_adv, bit_period)) begin
                  echo.valid   = 1'b1;
                  echo.data    = rx_cur.shift;
                  rx_nxt.shift = '0;
                  rx_nxt.bits  = '0;
                  rx_nxt.phase = RX_WAIT;
               end
            end
            default: begin
               rx_nxt = rx_cur;
            end
         endcase
      end
   end

endmodule

// ----- design/hdue_tx.sv -----
// Transmitter step: echo and send arbitration, then frame sequencing.
`timescale 1ns / 1ps

module hdue_tx (
   input  logic                              send_valid,
   input  logic [hdue_pkg::BYTE_WIDTH-1:0]   send_byte,
   input  hdue_pkg::echo_type                echo,
   input  logic [hdue_pkg::TICK_WIDTH-1:0]   tick_count,
   input  logic [hdue_pkg::CFG_WIDTH-1:0]    bit_period,
   input  hdue_pkg::tx_state_type            tx_cur,
   output hdue_pkg::tx_state_type            tx_nxt,
   output logic [hdue_pkg::TICK_WIDTH-1:0]   tick_nxt,
   output logic                              send_accepted
);
   import hdue_pkg::*;

   tx_state_type               tx_offer;
   logic [BIT_COUNT_WIDTH-1:0] bits_inc;
   logic                       bit_due;

   always_comb begin
      tx_offer      = tx_cur;
      send_accepted = 1'b0;
      if (echo.valid && !tx_offer.busy) begin
         tx_offer.shift = echo.data;
         tx_offer.busy  = 1'b1;
      end
      if (send_valid && !tx_offer.busy) begin
         tx_offer.shift = send_byte;
         tx_offer.busy  = 1'b1;
         send_accepted  = 1'b1;
      end
   end

   assign bits_inc = tx_offer.bits + BIT_COUNT_WIDTH'(1);
   assign bit_due  = tick_reached(tick_count, bit_period);

   always_comb begin
      tx_nxt   = tx_offer;
      tick_nxt = tick_count;
      case (tx_offer.phase)
         TX_DATA: begin
            if (bit_due) begin
               tx_nxt.level  = tx_offer.shift[0];
               tx_nxt.parity = tx_offer.parity ^ tx_offer.shift[0];
               tx_nxt.shift  = {1'b0, tx_offer.shift[BYTE_WIDTH-1:1]};
               tx_nxt.bits   = bits_inc;
               tick_nxt      = '0;
               if (bits_inc >= DATA_BITS_COUNT) begin
                  tx_nxt.phase = TX_PARITY;
               end
            end
         end
         TX_PARITY: begin
            if (bit_due) begin
               tx_nxt.level = tx_offer.parity;
               tick_nxt     = '0;
               tx_nxt.phase = TX_STOP;
            end
         end
         TX_STOP: begin
            if (bit_due) begin
               tx_nxt.level = 1'b1;
               tick_nxt     = '0;
               tx_nxt.phase = TX_HOLD;
            end
         end
         TX_HOLD: begin
            if (bit_due) begin
               tx_nxt.busy  = 1'b0;
               tx_nxt.phase = TX_IDLE;
            end
         end
         default: begin
            if (tx_offer.busy) begin
               tx_nxt.level  = 1'b0;
               tx_nxt.bits   = '0;
               tx_nxt.parity = 1'b0;
               tick_nxt      = '0;
               tx_nxt.phase  = TX_DATA;
            end else begin
               tx_nxt.phase = TX_IDLE;
            end
         end
      endcase
   end

endmodule

// ----- design/half_duplex_uart_even_parity_echo_unit.sv -----
// Top level of the half-duplex 8E1 UART echo unit: state, config and output register.
`timescale 1ns / 1ps

// Each req transaction is one poll of the line (tick flag, receive level, optional
// send request) and yields exactly one rsp transaction carrying the transmit level,
// busy flag, send acceptance and any completed received byte. A poll is taken every
// clock while req_stall is low; its result appears in the output register on the
// next cycle. The rate is set by the update of the shared tick counter and the
// receive/transmit state registers. req_stall rises only while a result waits in
// the output register and rsp_stall is high. Write bit_period and start_delay
// through the csr port only while no transaction is in flight.
module half_duplex_uart_even_parity_echo_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  hdue_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output hdue_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [hdue_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hdue_pkg::CFG_WIDTH-1:0]        csr_write_data
);
   import hdue_pkg::*;

   logic [CFG_WIDTH-1:0]  bit_period_ff, bit_period_in;
   logic [CFG_WIDTH-1:0]  start_delay_ff, start_delay_in;
   logic [TICK_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [TICK_WIDTH-1:0] tick_after_rx;
   rx_state_type          rx_ff, rx_in, rx_step;
   tx_state_type          tx_ff, tx_in, tx_step;
   echo_type              echo;
   logic                  send_accepted;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;
   logic                  req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   hdue_rx u_rx (
      .tick        (req_payload.tick),
      .rx_line     (req_payload.rx_line),
      .tx_busy     (tx_ff.busy),
      .tick_count  (tick_count_ff),
      .bit_period  (bit_period_ff),
      .start_delay (start_delay_ff),
      .rx_cur      (rx_ff),
      .rx_nxt      (rx_step),
      .tick_nxt    (tick_after_rx),
      .echo        (echo)
   );

   hdue_tx u_tx (
      .send_valid    (req_payload.send_valid),
      .send_byte     (req_payload.send_byte),
      .echo          (echo),
      .tick_count    (tick_after_rx),
      .bit_period    (bit_period_ff),
      .tx_cur        (tx_ff),
      .tx_nxt        (tx_step),
      .tick_nxt      (tick_count_in),
      .send_accepted (send_accepted)
   );

   always_comb begin
      bit_period_in  = bit_period_ff;
      start_delay_in = start_delay_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_PERIOD:  bit_period_in  = csr_write_data;
            CSR_START_DELAY: start_delay_in = csr_write_data;
            default: begin
               bit_period_in  = bit_period_ff;
               start_delay_in = start_delay_ff;
            end
         endcase
      end
   end

   assign rx_in = rx_step;
   assign tx_in = tx_step;

   always_comb begin
      rsp_payload_in.tx_line       = tx_step.level;
      rsp_payload_in.busy_res      = tx_step.busy;
      rsp_payload_in.send_accepted = send_accepted;
      rsp_payload_in.rx_valid      = echo.valid;
      rsp_payload_in.rx_byte       = echo.data;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= BIT_PERIOD_RESET;
         start_delay_ff <= START_DELAY_RESET;
         tick_count_ff  <= '0;
         rx_ff          <= '{phase: RX_WAIT, shift: '0, bits: '0};
         tx_ff          <= '{phase: TX_IDLE, shift: '0, bits: '0, parity: 1'b0,
                             level: 1'b1, busy: 1'b0};
         rsp_valid_ff   <= 1'b0;
      end else begin
         bit_period_ff  <= bit_period_in;
         start_delay_ff <= start_delay_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (req_accept) begin
            tick_count_ff <= tick_count_in;
            rx_ff         <= rx_in;
            tx_ff         <= tx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   a_echo_takes_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.rx_valid |->
         rsp_payload_ff.busy_res && !rsp_payload_ff.send_accepted)
      else $error("received byte not echoed or send not refused");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.send_accepted |-> rsp_payload_ff.busy_res)
      else $error("accepted send without busy transmitter");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      tx_ff.phase == TX_IDLE && !tx_ff.busy |-> tx_ff.level)
      else $error("transmit line low while idle");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(tick_count_ff) && $stable(rx_ff) && $stable(tx_ff))
      else $error("state advanced without an accepted transaction");

endmodule

// ----- verif/tb_half_duplex_uart_even_parity_echo_unit.sv -----
// Self-checking testbench for the half-duplex 8E1 UART echo unit.
`timescale 1ns / 1ps

module tb_half_duplex_uart_even_parity_echo_unit;
   import hdue_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = CSR_INDEX_WIDTH'(3);

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CFG_WIDTH-1:0]       data;
      req_type                    poll;
      logic                       typed;
      rsp_type                    want;
   } script_row_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] bit_period;
      logic [CFG_WIDTH-1:0] start_delay;
      logic [7:0]           idle_pct;
      logic [7:0]           stall_pct;
      logic [15:0]          polls;
      logic [7:0]           tick_pct;
      logic [7:0]           frame_pct;
      logic [7:0]           send_pct;
   } segment_type;

   localparam rsp_type NO_RSP    = '0;
   localparam req_type IDLE_POLL = '{1'b0, 1'b1, 1'b0, 8'h00};

   localparam script_row_type SCRIPT [0:28] = '{
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b0, 8'h00}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{ROW_CSR, CSR_BIT_PERIOD, 8'h00, IDLE_POLL, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_START_DELAY, 8'h00, IDLE_POLL, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_SPARE_A, 8'hFF, IDLE_POLL, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_SPARE_B, 8'hFF, IDLE_POLL, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b0, 1'b0, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'hFF}, 1'b1,
        '{1'b0, 1'b1, 1'b0, 1'b1, 8'hA5}},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b0, 1'b1, 1'b1, 8'h00}, 1'b0, NO_RSP},
      '{ROW_POLL, CSR_BIT_PERIOD, 8'h00, '{1'b1, 1'b1, 1'b1, 8'h00}, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}}
   };

   localparam segment_type PHASES [0:7] = '{
      '{8'd2,   8'd1,   8'd0,  8'd0,  16'd200, 8'd100, 8'd5, 8'd5},
      '{8'd1,   8'd0,   8'd75, 8'd0,  16'd200, 8'd60,  8'd5, 8'd10},
      '{8'd3,   8'd2,   8'd0,  8'd75, 16'd200, 8'd80,  8'd5, 8'd5},
      '{8'd0,   8'd0,   8'd30, 8'd30, 16'd200, 8'd50,  8'd5, 8'd10},
      '{8'd255, 8'd255, 8'd0,  8'd0,  16'd300, 8'd100, 8'd0, 8'd0},
      '{8'd255, 8'd0,   8'd30, 8'd30, 16'd150, 8'd100, 8'd5, 8'd20},
      '{8'd1,   8'd255, 8'd75, 8'd0,  16'd150, 8'd100, 8'd5, 8'd5},
      '{8'd2,   8'd1,   8'd0,  8'd75, 16'd100, 8'd70,  8'd5, 8'd5}
   };

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   req_type                    req_payload      = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CFG_WIDTH-1:0]       csr_write_data   = '0;

   int unsigned cycles             = 0;
   int          failures           = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   rsp_type     due_results [$];

   logic [CFG_WIDTH-1:0]       period_cfg   = BIT_PERIOD_RESET;
   logic [CFG_WIDTH-1:0]       delay_cfg    = START_DELAY_RESET;
   logic [TICK_WIDTH-1:0]      shared_ticks = '0;
   rx_phase_type               rcv_phase    = RX_WAIT;
   logic [BYTE_WIDTH-1:0]      rcv_shift    = '0;
   logic [BIT_COUNT_WIDTH-1:0] rcv_count    = '0;
   tx_phase_type               xmt_phase    = TX_IDLE;
   logic [BYTE_WIDTH-1:0]      xmt_shift    = '0;
   logic [BIT_COUNT_WIDTH-1:0] xmt_count    = '0;
   logic                       xmt_parity   = 1'b0;
   logic                       xmt_level    = 1'b1;
   logic                       xmt_busy     = 1'b0;

   int   frame_left  = 0;
   int   frame_hold  = 0;
   logic frame_level = 1'b1;

   half_duplex_uart_even_parity_echo_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic rsp_type poll_uart(input req_type poll);
      rsp_type res;
      res = '0;
      if (poll.tick && shared_ticks != TICK_MAX) shared_ticks = shared_ticks + 1'b1;
      if (!xmt_busy) begin
         case (rcv_phase)
            RX_WAIT: begin
               if (!poll.rx_line) begin
                  shared_ticks = '0;
                  rcv_phase    = RX_DELAY;
               end
            end
            RX_DELAY: begin
               if (shared_ticks >= delay_cfg) begin
                  shared_ticks = '0;
                  rcv_phase    = RX_DATA;
               end
            end
            RX_DATA: begin
               if (shared_ticks >= period_cfg) begin
                  if (rcv_count < DATA_BITS_COUNT) begin
                     rcv_shift = {poll.rx_line, rcv_shift[BYTE_WIDTH-1:1]};
                     rcv_count = rcv_count + 1'b1;
                  end else begin
                     rcv_phase = RX_STOP;
                  end
                  shared_ticks = '0;
               end
            end
            default: begin
               if (shared_ticks >= period_cfg) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = rcv_shift;
                  xmt_shift    = rcv_shift;
                  xmt_busy     = 1'b1;
                  rcv_shift    = '0;
                  rcv_count    = '0;
                  rcv_phase    = RX_WAIT;
               end
            end
         endcase
      end
      if (poll.send_valid && !xmt_busy) begin
         xmt_shift         = poll.send_byte;
         xmt_busy          = 1'b1;
         res.send_accepted = 1'b1;
      end
      case (xmt_phase)
         TX_DATA: begin
            if (shared_ticks >= period_cfg) begin
               xmt_level    = xmt_shift[0];
               xmt_parity   = xmt_parity ^ xmt_level;
               xmt_shift    = xmt_shift >> 1;
               xmt_count    = xmt_count + 1'b1;
               shared_ticks = '0;
               if (xmt_count >= DATA_BITS_COUNT) xmt_phase = TX_PARITY;
            end
         end
         TX_PARITY: begin
            if (shared_ticks >= period_cfg) begin
               xmt_level    = xmt_parity;
               shared_ticks = '0;
               xmt_phase    = TX_STOP;
            end
         end
         TX_STOP: begin
            if (shared_ticks >= period_cfg) begin
               xmt_level    = 1'b1;
               shared_ticks = '0;
               xmt_phase    = TX_HOLD;
            end
         end
         TX_HOLD: begin
            if (shared_ticks >= period_cfg) begin
               xmt_busy  = 1'b0;
               xmt_phase = TX_IDLE;
            end
         end
         default: begin
            if (xmt_busy) begin
               xmt_level    = 1'b0;
               xmt_count    = '0;
               xmt_parity   = 1'b0;
               shared_ticks = '0;
               xmt_phase    = TX_DATA;
            end else begin
               xmt_phase = TX_IDLE;
            end
         end
      endcase
      res.tx_line  = xmt_level;
      res.busy_res = xmt_busy;
      return res;
   endfunction

   function automatic req_type next_poll(input segment_type seg);
      req_type poll;
      poll.tick       = ($urandom_range(0, 99) < seg.tick_pct);
      poll.send_valid = ($urandom_range(0, 99) < seg.send_pct);
      poll.send_byte  = BYTE_WIDTH'($urandom_range(0, 255));
      if (frame_left == 0) begin
         if ($urandom_range(0, 99) < seg.frame_pct) begin
            frame_left  = 11;
            frame_level = 1'b0;
            frame_hold  = (period_cfg == '0) ? 1 : int'(period_cfg);
         end
      end else if (poll.tick) begin
         if (frame_hold > 1) begin
            frame_hold = frame_hold - 1;
         end else begin
            frame_left  = frame_left - 1;
            frame_level = (frame_left <= 1) ? 1'b1 : 1'($urandom_range(0, 1));
            frame_hold  = (period_cfg == '0) ? 1 : int'(period_cfg);
         end
      end
      poll.rx_line = (frame_left == 0) ? 1'b1 : frame_level;
      if (seg.frame_pct != 0 && $urandom_range(0, 99) < 2) poll.rx_line = ~poll.rx_line;
      return poll;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic offer_poll(input req_type poll, input logic typed, input rsp_type want);
      rsp_type predicted;
      csr_write_enable <= 1'b0;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= poll;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = poll_uart(poll);
      due_results.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CFG_WIDTH-1:0] value);
      csr_index        <= index;
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      if (index == CSR_BIT_PERIOD) period_cfg = value;
      else if (index == CSR_START_DELAY) delay_cfg = value;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: transaction expected none actual %h", $time, rsp_payload);
            failures++;
         end else begin
            expected = due_results.pop_front();
            check_field("tx_line", 8'(expected.tx_line), 8'(rsp_payload.tx_line));
            check_field("busy_res", 8'(expected.busy_res), 8'(rsp_payload.busy_res));
            check_field("send_accepted", 8'(expected.send_accepted),
                        8'(rsp_payload.send_accepted));
            check_field("rx_valid", 8'(expected.rx_valid), 8'(rsp_payload.rx_valid));
            check_field("rx_byte", expected.rx_byte, rsp_payload.rx_byte);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_half_duplex_uart_even_parity_echo_unit: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            settle();
            write_reg(SCRIPT[i].index, SCRIPT[i].data);
         end else begin
            offer_poll(SCRIPT[i].poll, SCRIPT[i].typed, SCRIPT[i].want);
         end
      end

      foreach (PHASES[s]) begin
         settle();
         write_reg(CSR_BIT_PERIOD, PHASES[s].bit_period);
         write_reg(CSR_START_DELAY, PHASES[s].start_delay);
         sender_idle_pct    = PHASES[s].idle_pct;
         receiver_stall_pct = PHASES[s].stall_pct;
         repeat (PHASES[s].polls) offer_poll(next_poll(PHASES[s]), 1'b0, NO_RSP);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_half_duplex_uart_even_parity_echo_unit: PASS");
      end else begin
         $display("tb_half_duplex_uart_even_parity_echo_unit: FAIL");
      end
      $finish;
   end

endmodule

// ----- half_duplex_uart_even_parity_echo_unit.f -----
design/hdue_pkg.sv
design/hdue_rx.sv
design/hdue_tx.sv
design/half_duplex_uart_even_parity_echo_unit.sv
verif/tb_half_duplex_uart_even_parity_echo_unit.sv
